FILE: sv/polar_sector_classifier_macros.svh
// Assertion macros shared by the sector classifier RTL.
// No dependencies.
`ifndef POLAR_SECTOR_CLASSIFIER_MACROS_SVH
`define POLAR_SECTOR_CLASSIFIER_MACROS_SVH
`ifndef ASSERT_OFF
`define PSC_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define PSC_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PSC_ASSERT(label, clk, rst, prop, msg)
`define PSC_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

FILE: sv/psc_pkg.sv
// Shared types and constants for the polar sector classifier.
// No dependencies.
package psc_pkg;
  localparam int AtanEntries = 24;
  localparam int AngBits = 26;
  localparam logic [AngBits-1:0] HalfTurn = 26'(180 * 65536);
  localparam logic [AngBits-1:0] FullTurn = 26'(360 * 65536);

  typedef enum logic [1:0] {ST_IDLE, ST_CORDIC, ST_WALK, ST_DONE} state_t;

  typedef struct packed {
    logic [AngBits-1:0] lo;
    logic               hit;
    logic [3:0]         idx;
  } walk_t;

  function automatic logic [AngBits-1:0] atan_at(input logic [4:0] i);
    logic [AngBits-1:0] r;
    begin
      case (i)
        5'd0: r = 26'd2949120;  5'd1: r = 26'd1740967;  5'd2: r = 26'd919879;
        5'd3: r = 26'd466945;   5'd4: r = 26'd234379;   5'd5: r = 26'd117304;
        5'd6: r = 26'd58666;    5'd7: r = 26'd29335;    5'd8: r = 26'd14668;
        5'd9: r = 26'd7334;     5'd10: r = 26'd3667;    5'd11: r = 26'd1833;
        5'd12: r = 26'd917;     5'd13: r = 26'd458;     5'd14: r = 26'd229;
        5'd15: r = 26'd115;     5'd16: r = 26'd57;      5'd17: r = 26'd29;
        5'd18: r = 26'd14;      5'd19: r = 26'd7;       5'd20: r = 26'd4;
        5'd21: r = 26'd2;       5'd22: r = 26'd1;       default: r = '0;
      endcase
      return r;
    end
  endfunction
endpackage

FILE: sv/psc_cordic_cell.sv
// One CORDIC micro-rotation cell; a row of these forms the angle pipeline.
// Depends on psc_pkg.
module psc_cordic_cell import psc_pkg::*; #(
  parameter int W = 20,
  parameter int STEP = 0
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [W-1:0] x_in,
  input  logic signed [W-1:0] y_in,
  input  logic [AngBits-1:0]  z_in,
  output logic signed [W-1:0] x_out,
  output logic signed [W-1:0] y_out,
  output logic [AngBits-1:0]  z_out
);
  logic signed [W-1:0] dx, dy;
  logic [AngBits-1:0] a;
  assign dx = y_in >>> STEP;
  assign dy = x_in >>> STEP;
  assign a  = atan_at(5'(STEP));

  // rotate toward the x axis, hand the result to the next cell
  always_ff @(posedge clk) begin
    if (en) begin
      if (!y_in[W-1]) begin
        x_out <= x_in + dx;
        y_out <= y_in - dy;
        z_out <= z_in + a;
      end else begin
        x_out <= x_in - dx;
        y_out <= y_in + dy;
        z_out <= z_in - a;
      end
    end
  end
endmodule

FILE: sv/psc_walk_cell.sv
// One sector-walk cell: tests one table entry's span and passes the running start on.
// Depends on psc_pkg.
module psc_walk_cell import psc_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic               clk,
  input  logic               en,
  input  logic               active,
  input  logic [AngBits-1:0] ang,
  input  logic [15:0]        width,
  input  walk_t              w_in,
  output walk_t              w_out
);
  // 16+16 bit whole-degree spans fit in 33 bits of Q.16
  logic [33:0] hi;
  logic        match;
  assign hi = 34'(w_in.lo) + {2'b0, width, 16'h0};
  assign match = active && !w_in.hit && (34'(ang) >= 34'(w_in.lo)) && (34'(ang) < hi);

  // sum the span; saturate start past any reachable angle
  always_ff @(posedge clk) begin
    if (en) begin
      w_out.lo  <= (hi >= 34'(FullTurn)) ? FullTurn : hi[AngBits-1:0];
      w_out.hit <= w_in.hit | match;
      w_out.idx <= match ? 4'(IDX) : w_in.idx;
    end
  end
endmodule

FILE: sv/polar_sector_classifier.sv
// Top level of the polar sector classifier: control, table, CORDIC row, walk row.
// Depends on psc_pkg, psc_cordic_cell, psc_walk_cell and the macro header.
//
// Usage: an item is taken when start is high and busy is low. opcode 0 writes
// sector entry entry_index (width and RGBA color) and gives no result;
// busy stays low, so loads can follow each other in every cycle.
// opcode 1 classifies point (point_x, point_y), signed Q11.4. The point is tested
// against circle_radius^2, its angle found by a row of CORDIC_STEPS cells (at
// most AtanEntries), and the sectors walked by a row of SECTORS cells (at most
// 16), one cell per clock each. A classify runs through the preload registers,
// the CORDIC row, the angle register, the walk row, ST_DONE and the result
// registers. busy stays high until done rises and drops during the result beat,
// so the next item can be taken at the edge that ends that beat.
// The result is on the result ports for one cycle, marked by done; the receiver
// cannot stall it.
// Registers on the APB port: circle_radius at 0x0, sector_count at 0x4.
// Reset clears control and registers; the sector table is not cleared and must
// be written before it is read.
`include "polar_sector_classifier_macros.svh"
module polar_sector_classifier import psc_pkg::*; #(
  parameter int SECTORS = 16,
  parameter int COORD_BITS = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  input  logic                  start,
  output logic                  busy,
  output logic                  done,
  input  logic                  opcode,
  input  logic [3:0]            entry_index,
  input  logic [15:0]           sector_degrees,
  input  logic [7:0]            color_red,
  input  logic [7:0]            color_green,
  input  logic [7:0]            color_blue,
  input  logic [7:0]            color_alpha,
  input  logic signed [COORD_BITS-1:0] point_x,
  input  logic signed [COORD_BITS-1:0] point_y,
  output logic                  inside_res,
  output logic [3:0]            hit_sector,
  output logic [7:0]            out_red,
  output logic [7:0]            out_green,
  output logic [7:0]            out_blue,
  output logic [7:0]            out_alpha
);
  localparam int NSTEPS = (CORDIC_STEPS > AtanEntries) ? AtanEntries : CORDIC_STEPS;
  localparam int NCELL = (SECTORS > 16) ? 16 : SECTORS;
  localparam int IW = (NCELL > 1) ? $clog2(NCELL) : 1;
  localparam int CW = COORD_BITS + 3;
  localparam int LAT = NSTEPS + NCELL + 1;
  localparam int CNTW = $clog2(LAT + 1);
  localparam int PW = 2 * COORD_BITS + 1;

  // ---- configuration
  logic [14:0] circle_radius;
  logic [4:0]  sector_count;
  logic        cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  always_ff @(posedge clk) begin
    if (rst) begin
      circle_radius <= '0;
      sector_count  <= '0;
    end else if (cfg_wr) begin
      if (paddr[2] == 1'b0) circle_radius <= pwdata[14:0];
      else                  sector_count  <= pwdata[4:0];
    end
  end
  assign prdata = paddr[2] ? {27'b0, sector_count} : {17'b0, circle_radius};

  // ---- sector table, one register per entry (widths read at fixed cell positions)
  logic [15:0] width_tab [NCELL];
  logic [31:0] color_tab [NCELL];
  logic        accept;
  assign accept = start && !busy;
  always_ff @(posedge clk) begin
    if (accept && !opcode && (32'(entry_index) < NCELL)) begin
      width_tab[entry_index[IW-1:0]] <= sector_degrees;
      color_tab[entry_index[IW-1:0]] <=
        {color_red, color_green, color_blue, color_alpha};
    end
  end

  // ---- control
  state_t state, state_next;
  logic [CNTW-1:0] cnt;
  logic            outside, zero_pt;
  logic [4:0]      n_used;
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (accept && opcode) state_next = ST_CORDIC;
      ST_CORDIC: if (cnt == CNTW'(NSTEPS)) state_next = ST_WALK;
      ST_WALK:   if (cnt == CNTW'(LAT)) state_next = ST_DONE;
      ST_DONE:   state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= (state == ST_IDLE) ? '0 : cnt + 1'b1;
    end
  end
  assign busy = (state != ST_IDLE);

  // ---- distance test and CORDIC preload
  logic signed [PW-1:0] xx, yy;
  logic [PW:0] d2;
  logic [29:0] r2;
  assign xx = PW'(point_x) * PW'(point_x);
  assign yy = PW'(point_y) * PW'(point_y);
  assign d2 = (PW+1)'(xx) + (PW+1)'(yy);
  assign r2 = 30'(circle_radius) * 30'(circle_radius);

  logic signed [CW-1:0] cx [NSTEPS+1];
  logic signed [CW-1:0] cy [NSTEPS+1];
  logic [AngBits-1:0]   cz [NSTEPS+1];
  always_ff @(posedge clk) begin
    if (accept && opcode) begin
      outside <= (d2 > (PW+1)'(r2));
      zero_pt <= (point_x == '0) && (point_y == '0);
      n_used  <= (32'(sector_count) > NCELL) ? 5'(NCELL) : sector_count;
      if (point_x[COORD_BITS-1]) begin
        cx[0] <= -CW'(point_x);
        cy[0] <= -CW'(point_y);
        cz[0] <= HalfTurn;
      end else begin
        cx[0] <= CW'(point_x);
        cy[0] <= CW'(point_y);
        cz[0] <= '0;
      end
    end
  end

  logic step_en;
  assign step_en = (state == ST_CORDIC);
  for (genvar i = 0; i < NSTEPS; i++) begin : g_cordic
    psc_cordic_cell #(.W(CW), .STEP(i)) u_cell (
      .clk(clk), .en(step_en),
      .x_in(cx[i]), .y_in(cy[i]), .z_in(cz[i]),
      .x_out(cx[i+1]), .y_out(cy[i+1]), .z_out(cz[i+1])
    );
  end

  // wrap the angle once into [0,360)
  logic [AngBits-1:0] ang;
  always_ff @(posedge clk) begin
    if (state == ST_CORDIC && cnt == CNTW'(NSTEPS)) begin
      if (zero_pt)                ang <= '0;
      else if (cz[NSTEPS][AngBits-1]) ang <= cz[NSTEPS] + FullTurn;
      else if (cz[NSTEPS] >= FullTurn) ang <= cz[NSTEPS] - FullTurn;
      else                        ang <= cz[NSTEPS];
    end
  end

  // ---- sector walk row
  walk_t wk [NCELL+1];
  logic  walk_en;
  assign walk_en = (state == ST_WALK);
  assign wk[0] = '{lo: '0, hit: 1'b0, idx: 4'd0};
  for (genvar j = 0; j < NCELL; j++) begin : g_walk
    psc_walk_cell #(.IDX(j)) u_cell (
      .clk(clk), .en(walk_en), .active(5'(j) < n_used), .ang(ang),
      .width(width_tab[j]), .w_in(wk[j]), .w_out(wk[j+1])
    );
  end

  // ---- result beat
  logic [31:0] col;
  logic        hit;
  assign hit = wk[NCELL].hit && !outside;
  assign col = color_tab[wk[NCELL].idx[IW-1:0]];
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= (state == ST_DONE);
  end
  always_ff @(posedge clk) begin
    if (state == ST_DONE) begin
      inside_res <= hit;
      hit_sector <= hit ? wk[NCELL].idx : 4'd0;
      {out_red, out_green, out_blue, out_alpha} <= hit ? col : 32'd0;
    end
  end

  `PSC_ASSERT(a_done_after_run, clk, rst, done |-> $past(state) == ST_DONE, "done without run")
  `PSC_ASSERT(a_idle_after_done, clk, rst, done |-> !busy, "busy at result beat")
  `PSC_ASSERT(a_cfg_idle, clk, rst, (state == ST_WALK) |-> $stable(n_used), "count moved")
  `PSC_ASSERT_RST(a_rst_idle, clk, $past(rst) |-> state == ST_IDLE, "state after reset")
endmodule
